/* rtl/sapq_pkg.sv */
// Shared types and constants for the sorted-array minimum priority queue.
// Used by the controller, the datapath and the top level; no dependencies.
package sapq_pkg;

   localparam int DEF_CAPACITY  = 8;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // request action codes
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   typedef struct packed {
      logic                      action;
      logic signed [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } rsp_word_type;

   typedef enum logic [1:0] {
      RD_AT_POS,
      RD_BELOW_POS,
      RD_ABOVE_POS
   } rd_addr_sel_type;

   typedef enum logic {
      WR_READ_DATA,
      WR_NEW_VALUE
   } wr_data_sel_type;

   // controller to datapath
   typedef struct packed {
      logic                load_item;
      logic                rd_en;
      rd_addr_sel_type     rd_sel;
      logic                wr_en;
      wr_data_sel_type     wr_sel;
      logic                pos_inc;
      logic                pos_dec;
      logic                count_inc;
      logic                count_dec;
      logic                take_removed;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                rsp_load;
   } sapq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic pos_zero;
      logic less;
      logic rem_last;
      logic rsp_free;
   } sapq_stat_type;

endpackage

/* rtl/sapq_ctrl.sv */
// Sequencer for the sorted-array priority queue: steps inserts and removes
// one memory access at a time. Depends on sapq_pkg.
module sapq_ctrl
   import sapq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  sapq_stat_type stat,
   output sapq_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_INS_CHECK,
      ST_INS_CMP,
      ST_INS_PLACE,
      ST_REM_FIRST,
      ST_REM_CHECK,
      ST_REM_MOVE,
      ST_REM_DONE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   assign req_stall = req_stall_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_AT_POS;
      cmd.wr_sel = WR_READ_DATA;
      cmd.status = STATUS_DONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.is_remove) begin
               if (stat.empty) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STATUS_UNDERFLOW;
                  state_in       = ST_FINISH;
               end else begin
                  // fetch the smallest entry from slot zero
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_AT_POS;
                  state_in   = ST_REM_FIRST;
               end
            end else begin
               if (stat.full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STATUS_OVERFLOW;
                  state_in       = ST_FINISH;
               end else begin
                  state_in = ST_INS_CHECK;
               end
            end
         end
         ST_INS_CHECK: begin
            if (stat.pos_zero) begin
               state_in = ST_INS_PLACE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BELOW_POS;
               state_in   = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            // shift the larger neighbour up, else stop here
            if (stat.less) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_READ_DATA;
               cmd.pos_dec = 1'b1;
               state_in    = ST_INS_CHECK;
            end else begin
               state_in = ST_INS_PLACE;
            end
         end
         ST_INS_PLACE: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_NEW_VALUE;
            cmd.count_inc = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_REM_FIRST: begin
            cmd.take_removed = 1'b1;
            state_in         = ST_REM_CHECK;
         end
         ST_REM_CHECK: begin
            if (stat.rem_last) begin
               state_in = ST_REM_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ABOVE_POS;
               state_in   = ST_REM_MOVE;
            end
         end
         ST_REM_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_READ_DATA;
            cmd.pos_inc = 1'b1;
            state_in    = ST_REM_CHECK;
         end
         ST_REM_DONE: begin
            cmd.count_dec = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the word
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and the registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   // a word is taken only when the sequencer is idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |-> state_ff == ST_IDLE && !req_stall_ff)
      else $error("item loaded outside idle");

   // results leave only once all memory traffic has finished
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !cmd.wr_en && !cmd.rd_en && !cmd.count_inc && !cmd.count_dec)
      else $error("response loaded during memory traffic");

   // stall tracks the sequencer
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall_ff |-> state_ff != ST_IDLE)
      else $error("stall raised while idle");

endmodule

/* rtl/sapq_datapath.sv */
// Datapath for the sorted-array priority queue: entry memory, fill count,
// position pointer, item and result registers. Depends on sapq_pkg.
module sapq_datapath
   import sapq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_word,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word,
   input  sapq_cmd_type  cmd,
   output sapq_stat_type stat
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic signed [VALUE_W-1:0] mem [CAPACITY];

   logic                      action_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          pos_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic signed [VALUE_W-1:0] removed_ff;
   logic [STATUS_W-1:0]       status_ff;
   logic                      rsp_valid_ff;
   rsp_word_type              rsp_word_ff;

   logic [CNT_W-1:0]          pos_inc;
   logic [CNT_W-1:0]          pos_dec;
   logic [CNT_W-1:0]          rd_pos;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   assign pos_inc = pos_ff + CNT_W'(1);
   assign pos_dec = pos_ff - CNT_W'(1);

   // select read slot
   always_comb begin
      case (cmd.rd_sel)
         RD_BELOW_POS: rd_pos = pos_dec;
         RD_ABOVE_POS: rd_pos = pos_inc;
         default:      rd_pos = pos_ff;
      endcase
   end

   assign rd_addr = rd_pos[ADDR_W-1:0];
   assign wr_addr = pos_ff[ADDR_W-1:0];
   assign wr_data = (cmd.wr_sel == WR_NEW_VALUE) ? value_ff : rd_data_ff;

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // item, pointer, count and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         if (cmd.load_item) begin
            pos_ff <= (req_word.action == ACTION_REMOVE) ? '0 : count_ff;
         end else if (cmd.pos_inc) begin
            pos_ff <= pos_inc;
         end else if (cmd.pos_dec) begin
            pos_ff <= pos_dec;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff  <= req_word.action;
         value_ff   <= req_word.value;
         removed_ff <= '0;
         status_ff  <= STATUS_DONE;
      end else begin
         if (cmd.take_removed) begin
            removed_ff <= rd_data_ff;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
   end

   // output register: load on finish, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_word_ff.status        <= status_ff;
         rsp_word_ff.removed_value <= removed_ff;
         rsp_word_ff.entry_count   <= ENTRY_COUNT_W'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // status to the controller
   assign stat.is_remove = (action_ff == ACTION_REMOVE);
   assign stat.full      = (count_ff >= CAP_CNT);
   assign stat.empty     = (count_ff == '0);
   assign stat.pos_zero  = (pos_ff == '0);
   assign stat.less      = (value_ff < rd_data_ff);
   assign stat.rem_last  = (pos_inc >= count_ff);
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("fill count above capacity");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= count_ff)
      else $error("position beyond fill count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("fill count did not advance");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && status_ff != STATUS_DONE |-> removed_ff == '0)
      else $error("error result carries a value");

endmodule

/* rtl/sorted_array_min_priority_queue_core.sv */
// Sorted-array minimum priority queue: one result word per request word.
// An insert shifts each larger entry up one slot, then writes the new value;
// a remove takes slot zero and moves each later entry down one slot.
// One item at a time; each shift step is a read then a write of the one-write,
// one-read entry memory. No new request is taken until the result has entered
// the output register. Reset empties the queue at once; entry memory is not cleared.
module sorted_array_min_priority_queue_core
   import sapq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   sapq_cmd_type  cmd;
   sapq_stat_type stat;

   sapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sapq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
